// File: sv/b64e_pkg.sv
// Shared types, constants and the character table for the Base64 stream encoder.
// No dependencies; every other file imports this package.
`default_nettype none

package b64e_pkg;

	// One message byte as it arrives on the input channel.
	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_message;
	} byte_item_t;

	// One encoded character as it leaves on the output channel.
	typedef struct packed {
		logic [6:0] code_char;
		logic       end_of_text;
	} char_item_t;

	// A complete or zero-filled group of three bytes, ready for encoding.
	typedef struct packed {
		logic [7:0] b0;
		logic [7:0] b1;
		logic [7:0] b2;
		logic [2:0] num_chars;  // data characters, two to four; the rest are padding
		logic       last;       // group closes the message
	} group_t;

	localparam int unsigned QueueDepth = 2;
	localparam int unsigned CharsPerGroup = 4;

	localparam logic [2:0] CharsOneByte = 3'd2;
	localparam logic [2:0] CharsTwoBytes = 3'd3;
	localparam logic [2:0] CharsFull = 3'd4;

	localparam logic [6:0] PadChar = 7'h3d;

	// Map a six-bit value onto the standard alphabet A-Z a-z 0-9 + /.
	function automatic logic [6:0] sextet_char(input logic [5:0] s);
		logic [6:0] c;
		if (s < 6'd26) begin
			c = 7'h41 + {1'b0, s};
		end else if (s < 6'd52) begin
			c = 7'h61 + {1'b0, s - 6'd26};
		end else if (s < 6'd62) begin
			c = 7'h30 + {1'b0, s - 6'd52};
		end else if (s == 6'd62) begin
			c = 7'h2b;
		end else begin
			c = 7'h2f;
		end
		return c;
	endfunction

endpackage

`default_nettype wire

// File: sv/base64_stream_encoder.sv
// Base64 stream encoder: one byte per transfer in, one ASCII character per transfer out.
// A group is stored in the queue, then in grp_q, then its characters reach char_q.
// Throughput: one character per cycle from the back end unless the output stalls.
// A queue of QueueDepth groups lets bytes keep arriving while characters are stalled.
// Reset (arst_n low, asynchronous) empties the group, the queue and the output register.
`default_nettype none

module base64_stream_encoder import b64e_pkg::*; #(
	parameter int unsigned GroupQueueDepth = QueueDepth
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        byte_valid,
	output logic       byte_stall,
	input  byte_item_t byte_item,
	output logic       char_valid,
	input  wire        char_stall,
	output char_item_t char_item
);

	logic   push_valid;
	logic   push_ready;
	group_t push_group;
	logic   pop_valid;
	logic   pop_ready;
	group_t pop_group;

	// Byte intake and grouping.
	b64e_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_item  (byte_item),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_group (push_group)
	);

	// Group queue.
	b64e_queue #(
		.Depth (GroupQueueDepth)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_group (push_group),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_group  (pop_group)
	);

	// Character generation.
	b64e_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_group  (pop_group),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_item  (char_item)
	);

endmodule

`default_nettype wire

// File: sv/b64e_front.sv
// Front end of the Base64 encoder: accepts bytes and assembles three-byte groups.
// Depends on b64e_pkg; feeds group records into b64e_queue.
`default_nettype none

module b64e_front import b64e_pkg::*; (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        byte_valid,
	output logic       byte_stall,
	input  byte_item_t byte_item,
	output logic       push_valid,
	input  wire        push_ready,
	output group_t     push_group
);

	logic [1:0] phase_q;
	logic [7:0] pend0_q;
	logic [7:0] pend1_q;
	logic       accept;

	// Hold the input whenever the queue cannot take a group.
	assign byte_stall = !push_ready;
	assign accept = byte_valid && push_ready;

	// Classify the byte: store it, or close a group with it.
	always_comb begin
		push_group = '0;
		push_valid = 1'b0;
		case (phase_q)
			2'd1: begin
				push_group.b0 = pend0_q;
				push_group.b1 = byte_item.data_byte;
				push_group.num_chars = CharsTwoBytes;
				push_group.last = 1'b1;
				push_valid = byte_valid && byte_item.end_of_message;
			end
			2'd2: begin
				push_group.b0 = pend0_q;
				push_group.b1 = pend1_q;
				push_group.b2 = byte_item.data_byte;
				push_group.num_chars = CharsFull;
				push_group.last = byte_item.end_of_message;
				push_valid = byte_valid;
			end
			default: begin
				push_group.b0 = byte_item.data_byte;
				push_group.num_chars = CharsOneByte;
				push_group.last = 1'b1;
				push_valid = byte_valid && byte_item.end_of_message;
			end
		endcase
	end

	// Group position; a final byte or a full group returns it to empty.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 2'd0;
		end else if (accept) begin
			if (byte_item.end_of_message || phase_q == 2'd2) begin
				phase_q <= 2'd0;
			end else if (phase_q == 2'd1) begin
				phase_q <= 2'd2;
			end else begin
				phase_q <= 2'd1;
			end
		end
	end

	// Pending bytes of the open group.
	always_ff @(posedge clk) begin
		if (accept && !byte_item.end_of_message) begin
			if (phase_q == 2'd1) begin
				pend1_q <= byte_item.data_byte;
			end else if (phase_q != 2'd2) begin
				pend0_q <= byte_item.data_byte;
			end
		end
	end

endmodule

`default_nettype wire

// File: sv/b64e_queue.sv
// Short group queue between the front and back ends of the Base64 encoder.
// Depends on b64e_pkg for the group record type.
`default_nettype none

module b64e_queue import b64e_pkg::*; #(
	parameter int unsigned Depth = QueueDepth  // two or more entries
) (
	input  wire    clk,
	input  wire    arst_n,
	input  wire    push_valid,
	output logic   push_ready,
	input  group_t push_group,
	output logic   pop_valid,
	input  wire    pop_ready,
	output group_t pop_group
);

	localparam int unsigned PtrW = $clog2(Depth);
	localparam int unsigned CntW = $clog2(Depth + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
	localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

	group_t          entry_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic            do_push;
	logic            do_pop;

	assign push_ready = count_q != FullCnt;
	assign pop_valid = count_q != '0;
	assign pop_group = entry_q[rd_ptr_q];
	assign do_push = push_valid && push_ready;
	assign do_pop = pop_valid && pop_ready;

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_group;
		end
	end

endmodule

`default_nettype wire

// File: sv/b64e_back.sv
// Base64 back end: turns a group into four characters, one per cycle unless stalled.
// Depends on b64e_pkg for types and the character table; drains b64e_queue.
`default_nettype none

module b64e_back import b64e_pkg::*; (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        pop_valid,
	output logic       pop_ready,
	input  group_t     pop_group,
	output logic       char_valid,
	input  wire        char_stall,
	output char_item_t char_item
);

	localparam logic [1:0] LastIdx = 2'(CharsPerGroup - 1);

	group_t     grp_q;
	logic       busy_q;
	logic [1:0] idx_q;
	logic       char_valid_q;
	char_item_t char_q;
	logic       can_load;
	logic [5:0] sextet;
	char_item_t next_char;

	// The output register takes a new character when empty or being drained.
	assign can_load = !char_valid_q || !char_stall;
	assign pop_ready = !busy_q || (can_load && idx_q == LastIdx);

	// Pick the six bits for the current position and encode or pad.
	always_comb begin
		case (idx_q)
			2'd0: sextet = grp_q.b0[7:2];
			2'd1: sextet = {grp_q.b0[1:0], grp_q.b1[7:4]};
			2'd2: sextet = {grp_q.b1[3:0], grp_q.b2[7:6]};
			default: sextet = grp_q.b2[5:0];
		endcase
		next_char.code_char = ({1'b0, idx_q} < grp_q.num_chars) ? sextet_char(sextet) : PadChar;
		next_char.end_of_text = grp_q.last && idx_q == LastIdx;
	end

	// Sequencer: character position, active group and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q <= '0;
			char_valid_q <= 1'b0;
		end else begin
			if (can_load) begin
				char_valid_q <= busy_q;
			end
			if (busy_q && can_load) begin
				idx_q <= idx_q + 1'b1;
				if (idx_q == LastIdx) begin
					busy_q <= pop_valid;
				end
			end else if (!busy_q) begin
				busy_q <= pop_valid;
			end
		end
	end

	// Group and output character registers.
	always_ff @(posedge clk) begin
		if (pop_valid && pop_ready) begin
			grp_q <= pop_group;
		end
		if (busy_q && can_load) begin
			char_q <= next_char;
		end
	end

	assign char_valid = char_valid_q;
	assign char_item = char_q;

endmodule

`default_nettype wire

// File: sim/b64_stream_checker.sv
// Checker for the Base64 stream encoder: predicts the characters of every accepted byte
// and compares them with the character transfers. Depends on b64e_pkg.
module b64_stream_checker import b64e_pkg::*; (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         byte_valid,
	input  wire         byte_stall,
	input  byte_item_t  byte_item,
	input  wire         char_valid,
	input  wire         char_stall,
	input  char_item_t  char_item,
	output int unsigned pending_count,
	output int unsigned fail_count
);

	localparam logic [8*64-1:0] Base64Alphabet =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

	// Bytes waiting for their group to fill, and how many of them there are.
	logic [7:0]  held_bytes [2];
	logic [1:0]  held_count = 2'd0;
	char_item_t  predicted_chars [$];
	int unsigned mismatches = 0;
	int unsigned queued_chars = 0;

	assign pending_count = queued_chars;
	assign fail_count = mismatches;

	// Character k of the alphabet sits k bytes down from the top of the string.
	function automatic logic [6:0] alphabet_char(input logic [5:0] sextet);
		logic [7:0] c;
		c = Base64Alphabet[8*(63 - int'(sextet)) +: 8];
		return c[6:0];
	endfunction

	// Split a group into four sextets; those past the data characters become padding.
	task automatic predict_group(input logic [7:0] b0, input logic [7:0] b1,
			input logic [7:0] b2, input logic [2:0] data_chars, input logic closes);
		logic [23:0] group_bits;
		char_item_t  c;
		group_bits = {b0, b1, b2};
		for (int k = 0; k < CharsPerGroup; k++) begin
			c.code_char = (k < data_chars) ? alphabet_char(group_bits[23 - 6*k -: 6]) : PadChar;
			c.end_of_text = closes && (k == CharsPerGroup - 1);
			predicted_chars = {predicted_chars, c};
		end
	endtask

	// Advance the group by one byte; a full group or the end of the message emits four characters.
	task automatic encode_byte(input byte_item_t item);
		case (held_count)
			2'd1: begin
				if (item.end_of_message) begin
					predict_group(held_bytes[0], item.data_byte, 8'h00, CharsTwoBytes, 1'b1);
					held_count = 2'd0;
				end else begin
					held_bytes[1] = item.data_byte;
					held_count = 2'd2;
				end
			end
			2'd2: begin
				predict_group(held_bytes[0], held_bytes[1], item.data_byte, CharsFull,
					item.end_of_message);
				held_count = 2'd0;
			end
			default: begin
				if (item.end_of_message) begin
					predict_group(item.data_byte, 8'h00, 8'h00, CharsOneByte, 1'b1);
					held_count = 2'd0;
				end else begin
					held_bytes[0] = item.data_byte;
					held_count = 2'd1;
				end
			end
		endcase
	endtask

	// Compare each character transfer with the oldest prediction, then predict from the byte transfer.
	always @(posedge clk) begin : watch
		char_item_t oldest;
		if (arst_n) begin
			if (char_valid && !char_stall) begin
				if (predicted_chars.size() == 0) begin
					$display("%0t: character %h with nothing expected", $time, char_item);
					mismatches++;
				end else begin
					oldest = predicted_chars.pop_front();
					if (char_item.code_char !== oldest.code_char) begin
						$display("%0t: code_char expected %h, got %h", $time,
							oldest.code_char, char_item.code_char);
						mismatches++;
					end
					if (char_item.end_of_text !== oldest.end_of_text) begin
						$display("%0t: end_of_text expected %b, got %b", $time,
							oldest.end_of_text, char_item.end_of_text);
						mismatches++;
					end
				end
			end
			if (byte_valid && !byte_stall) begin
				encode_byte(byte_item);
			end
		end
		queued_chars <= predicted_chars.size();
	end

endmodule

// File: sim/tb_base64_stream_encoder.sv
// Testbench top for the Base64 stream encoder: resets the block, sends directed and random
// messages under varying idle and stall rates, and reports the verdict. Depends on b64e_pkg,
// base64_stream_encoder and b64_stream_checker.
module tb_base64_stream_encoder;
	import b64e_pkg::*;

	localparam int unsigned RandomBytes = 410;
	localparam int unsigned CycleLimit = 200000;
	localparam int unsigned SettleCycles = 20;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        byte_valid = 1'b0;
	byte_item_t  byte_item = '0;
	logic        char_stall = 1'b0;
	logic        byte_stall;
	logic        char_valid;
	char_item_t  char_item;
	int unsigned pending_count;
	int unsigned fail_count;
	int unsigned send_gap_pct = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned cycle_count = 0;

	always #5 clk = ~clk;

	base64_stream_encoder dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_item  (byte_item),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_item  (char_item)
	);

	b64_stream_checker stream_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.byte_valid    (byte_valid),
		.byte_stall    (byte_stall),
		.byte_item     (byte_item),
		.char_valid    (char_valid),
		.char_stall    (char_stall),
		.char_item     (char_item),
		.pending_count (pending_count),
		.fail_count    (fail_count)
	);

	// The receiver stalls at random at the current rate.
	always @(posedge clk) begin
		char_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// Guard against a hung block.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CycleLimit) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// One byte transfer, after an optional random gap; valid stays high into the next byte.
	task automatic send_byte(input logic [7:0] value, input logic last);
		while ($urandom_range(99) < send_gap_pct) begin
			byte_valid <= 1'b0;
			@(posedge clk);
		end
		byte_valid <= 1'b1;
		byte_item <= '{data_byte: value, end_of_message: last};
		@(posedge clk);
		while (byte_stall) @(posedge clk);
	endtask

	// Hold off the sender until every predicted character has come out.
	task automatic drain_chars();
		byte_valid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0) @(posedge clk);
	endtask

	// Random messages of mostly short lengths, with extreme byte values mixed in.
	task automatic send_messages(input int unsigned total, input int unsigned gap_pct,
			input int unsigned stall_pct);
		int unsigned sent;
		int unsigned len;
		logic [7:0]  value;
		send_gap_pct = gap_pct;
		recv_stall_pct = stall_pct;
		sent = 0;
		while (sent < total) begin
			len = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
			for (int i = 0; i < len; i++) begin
				if ($urandom_range(7) == 0) begin
					value = $urandom_range(1) ? 8'hff : 8'h00;
				end else begin
					value = 8'($urandom_range(255));
				end
				send_byte(value, i == len - 1);
			end
			sent += len;
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_gap_pct = 9;
		recv_stall_pct = 72;

		// Messages of one byte: padding with two '=' characters.
		send_byte(8'h4d, 1'b1);
		send_byte(8'hff, 1'b1);
		send_byte(8'h00, 1'b1);
		send_byte(8'h80, 1'b1);
		send_byte(8'h01, 1'b1);
		// A message of two bytes: padding with one '='.
		send_byte(8'h00, 1'b0);
		send_byte(8'hff, 1'b1);
		// A full group closing the message, all '+' characters.
		send_byte(8'hfb, 1'b0);
		send_byte(8'hef, 1'b0);
		send_byte(8'hbe, 1'b1);
		// Full groups without the end mark, then a single byte closes the message.
		send_byte(8'hff, 1'b0);
		send_byte(8'hff, 1'b0);
		send_byte(8'hff, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h5a, 1'b1);
		// A full group followed by two closing bytes.
		send_byte(8'ha5, 1'b0);
		send_byte(8'h5a, 1'b0);
		send_byte(8'h3c, 1'b0);
		send_byte(8'hc3, 1'b0);
		send_byte(8'h81, 1'b1);

		send_messages(RandomBytes / 3, 9, 72);
		drain_chars();
		send_messages(RandomBytes / 3, 72, 9);
		drain_chars();
		send_messages(RandomBytes - 2 * (RandomBytes / 3), 0, 0);
		drain_chars();
		repeat (SettleCycles) @(posedge clk);

		if (fail_count == 0 && pending_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

// File: base64_stream_encoder.f
sv/b64e_pkg.sv
sv/b64e_front.sv
sv/b64e_queue.sv
sv/b64e_back.sv
sv/base64_stream_encoder.sv
sim/b64_stream_checker.sv
sim/tb_base64_stream_encoder.sv
